// ===== rtl/core/color_ramp_interpolator_assert.svh =====
// Assertion macros for the color ramp interpolator RTL.
// Depends on nothing; included by the modules that assert.
`ifndef COLOR_RAMP_INTERPOLATOR_ASSERT_SVH
`define COLOR_RAMP_INTERPOLATOR_ASSERT_SVH
// Implication checked on every clock edge outside reset.
`define CRI_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
// Condition that must always hold outside reset.
`define CRI_ASSERT_ALWAYS(label, clk, rst_n, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("assertion failed");
`endif

// ===== rtl/core/cri_pkg.sv =====
// Shared types and constants of the color ramp interpolator.
// Used by the modules under rtl/core other than cri_divider.
package cri_pkg;
    localparam int MaxNodes = 16;
    localparam int IdxW = $clog2(MaxNodes);
    localparam int CntW = $clog2(MaxNodes + 1);
    localparam int QDepth = 2;

    localparam logic OpInsert = 1'b0;
    localparam logic OpLookup = 1'b1;

    localparam logic [1:0] StOk = 2'd0;
    localparam logic [1:0] StEmpty = 2'd1;
    localparam logic [1:0] StFull = 2'd2;

    typedef struct packed {
        logic [15:0] pos;
        logic [7:0]  red;
        logic [7:0]  green;
        logic [7:0]  blue;
    } t_node;

    typedef struct packed {
        logic        op;
        t_node       node;
    } t_cmd;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic [1:0] status;
    } t_res;
endpackage

// ===== rtl/core/color_ramp_interpolator.sv =====
// Top level of the color ramp interpolator.
// Depends on cri_pkg, cri_front and cri_back.
//
// Keeps up to 16 color nodes sorted by position. An insert is done in the scan state of the
// back part. A lookup scans the table one node a cycle and, when the position lies between
// two nodes, runs the bit-serial divider once per color component; outside the nodes it
// takes the nearest end node. Items queue two deep ahead of the table; one result waits
// in the output register while the back part works on the next item.
module color_ramp_interpolator (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        push,
    output logic        full,
    input  logic        i_operation,
    input  logic [15:0] i_position,
    input  logic [7:0]  i_node_red,
    input  logic [7:0]  i_node_green,
    input  logic [7:0]  i_node_blue,
    output logic        empty,
    input  logic        pop,
    output logic [7:0]  o_out_red,
    output logic [7:0]  o_out_green,
    output logic [7:0]  o_out_blue,
    output logic [1:0]  o_status
);
    cri_pkg::t_cmd cmd_in, cmd_q;
    cri_pkg::t_res res;
    logic q_valid, take, res_valid;

    assign cmd_in = '{i_operation, '{i_position, i_node_red, i_node_green, i_node_blue}};

    cri_front u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_push(push), .i_cmd(cmd_in),
        .o_full(full), .i_take(take), .o_valid(q_valid), .o_cmd(cmd_q)
    );

    cri_back u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(q_valid), .i_cmd(cmd_q),
        .o_take(take), .o_res_valid(res_valid), .o_res(res),
        .i_res_take(pop && res_valid)
    );

    assign empty = !res_valid;
    assign o_out_red = res.red;
    assign o_out_green = res.green;
    assign o_out_blue = res.blue;
    assign o_status = res.status;
endmodule

// ===== rtl/core/cri_queue.sv =====
// Small FIFO of registers used between the front and back parts.
// Depends on cri_pkg.
module cri_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  cri_pkg::t_cmd i_data,
    output logic          o_full,
    input  logic          i_pop,
    output logic          o_empty,
    output cri_pkg::t_cmd o_data
);
    cri_pkg::t_cmd r_mem [cri_pkg::QDepth];
    logic r_wp, r_rp;
    logic [1:0] r_cnt;
    logic wr, rd;

    assign o_full = (r_cnt == 2'(cri_pkg::QDepth));
    assign o_empty = (r_cnt == 2'd0);
    assign o_data = r_mem[r_rp];
    assign wr = i_push && !o_full;
    assign rd = i_pop && !o_empty;

    // Pointer and count update.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= 1'b0;
            r_rp <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (wr) r_wp <= ~r_wp;
            if (rd) r_rp <= ~r_rp;
            r_cnt <= r_cnt + 2'(wr) - 2'(rd);
        end
    end

    // Storage write.
    always_ff @(posedge i_clk) begin
        if (wr) r_mem[r_wp] <= i_data;
    end
endmodule

// ===== rtl/core/cri_divider.sv =====
// Restoring divider: 24-bit numerator by 16-bit divisor, one bit per cycle.
// Depends on nothing else.
module cri_divider (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [23:0] i_num,
    input  logic [15:0] i_den,
    output logic        o_busy,
    output logic [7:0]  o_quot
);
    logic [16:0] r_rem;
    logic [23:0] r_q;
    logic [15:0] r_den;
    logic [4:0]  r_cnt;
    logic        r_busy;
    logic [16:0] trial;
    logic [16:0] sh;

    assign o_busy = r_busy;
    assign o_quot = r_q[7:0];
    assign sh = {r_rem[15:0], r_q[23]};
    assign trial = sh - {1'b0, r_den};

    // One quotient bit per cycle.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt <= 5'd0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt <= 5'd0;
            r_rem <= 17'd0;
            r_q <= i_num;
            r_den <= i_den;
        end else if (r_busy) begin
            if (!trial[16]) begin
                r_rem <= trial;
                r_q <= {r_q[22:0], 1'b1};
            end else begin
                r_rem <= sh;
                r_q <= {r_q[22:0], 1'b0};
            end
            r_cnt <= r_cnt + 5'd1;
            if (r_cnt == 5'd23) r_busy <= 1'b0;
        end
    end
endmodule

// ===== rtl/core/cri_back.sv =====
// Back part: node table, sorted insert and bracketed interpolation.
// Depends on cri_pkg, cri_divider and the assertion header.
`include "color_ramp_interpolator_assert.svh"
module cri_back (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    input  cri_pkg::t_cmd i_cmd,
    output logic          o_take,
    output logic          o_res_valid,
    output cri_pkg::t_res o_res,
    input  logic          i_res_take
);
    typedef enum logic [5:0] {
        S_IDLE = 6'b000001,
        S_SCAN = 6'b000010,
        S_DIV  = 6'b000100,
        S_WAIT = 6'b001000,
        S_NEXT = 6'b010000,
        S_OUT  = 6'b100000
    } t_state;

    t_state r_state;
    cri_pkg::t_node r_tab [cri_pkg::MaxNodes];
    logic [cri_pkg::CntW-1:0] r_count;
    cri_pkg::t_cmd r_cmd;
    cri_pkg::t_res r_res;
    cri_pkg::t_res r_out;
    logic r_res_valid;
    logic [cri_pkg::CntW-1:0] r_hi;
    logic [1:0] r_comp;
    logic [15:0] r_w, r_t;
    logic [7:0] r_lo_c [3];
    logic [7:0] r_up_c [3];
    logic [7:0] r_out_c [2];
    logic div_start, div_busy;
    logic [7:0] div_q;
    logic [23:0] div_num;
    logic [cri_pkg::CntW-1:0] k;
    logic hit;
    logic out_load;

    cri_divider u_div (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(div_start),
        .i_num(div_num), .i_den(r_w), .o_busy(div_busy), .o_quot(div_q)
    );

    // Sorted place: count of nodes below the position, over independent compares.
    always_comb begin
        k = '0;
        hit = 1'b0;
        for (int i = 0; i < cri_pkg::MaxNodes; i++) begin
            if (i < r_count) begin
                if (r_tab[i].pos < r_cmd.node.pos) k = k + 1'b1;
                if (r_tab[i].pos == r_cmd.node.pos) hit = 1'b1;
            end
        end
    end

    assign div_num = 24'(r_t) * 24'(r_up_c[r_comp] - r_lo_c[r_comp]);
    assign div_start = (r_state == S_DIV);
    assign o_take = (r_state == S_IDLE);
    assign o_res_valid = r_res_valid;
    assign o_res = r_out;
    // A finished item moves to the output register once it is free or being taken.
    assign out_load = (r_state == S_OUT) && (!r_res_valid || i_res_take);

    // Output register valid flag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_res_valid <= 1'b0;
        end else if (out_load) begin
            r_res_valid <= 1'b1;
        end else if (i_res_take) begin
            r_res_valid <= 1'b0;
        end
    end

    // Control sequencer.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (i_valid) begin
                        r_cmd <= i_cmd;
                        r_hi <= '0;
                        r_state <= S_SCAN;
                    end
                end
                S_SCAN: begin
                    if (r_cmd.op == cri_pkg::OpInsert) begin
                        r_state <= S_OUT;
                        if (hit) begin
                            r_tab[k[cri_pkg::IdxW-1:0]] <= r_cmd.node;
                            r_res <= '{8'd0, 8'd0, 8'd0, cri_pkg::StOk};
                        end else if (r_count == cri_pkg::CntW'(cri_pkg::MaxNodes)) begin
                            r_res <= '{8'd0, 8'd0, 8'd0, cri_pkg::StFull};
                        end else begin
                            for (int i = 1; i < cri_pkg::MaxNodes; i++) begin
                                if (i > k && i <= r_count) r_tab[i] <= r_tab[i-1];
                            end
                            r_tab[k[cri_pkg::IdxW-1:0]] <= r_cmd.node;
                            r_count <= r_count + 1'b1;
                            r_res <= '{8'd0, 8'd0, 8'd0, cri_pkg::StOk};
                        end
                    end else if (r_count == '0) begin
                        r_res <= '{8'd0, 8'd0, 8'd0, cri_pkg::StEmpty};
                        r_state <= S_OUT;
                    end else if (r_hi < r_count
                                 && r_tab[r_hi[cri_pkg::IdxW-1:0]].pos <= r_cmd.node.pos) begin
                        r_hi <= r_hi + 1'b1;
                    end else if (r_hi == '0 || r_hi == r_count) begin
                        if (r_hi == '0) begin
                            r_res <= '{r_tab[0].red, r_tab[0].green, r_tab[0].blue,
                                       cri_pkg::StOk};
                        end else begin
                            r_res <= '{r_tab[r_hi[cri_pkg::IdxW-1:0]-1'b1].red,
                                       r_tab[r_hi[cri_pkg::IdxW-1:0]-1'b1].green,
                                       r_tab[r_hi[cri_pkg::IdxW-1:0]-1'b1].blue,
                                       cri_pkg::StOk};
                        end
                        r_state <= S_OUT;
                    end else begin
                        r_w <= r_tab[r_hi[cri_pkg::IdxW-1:0]].pos
                             - r_tab[r_hi[cri_pkg::IdxW-1:0]-1'b1].pos;
                        r_t <= r_cmd.node.pos - r_tab[r_hi[cri_pkg::IdxW-1:0]-1'b1].pos;
                        r_lo_c[0] <= r_tab[r_hi[cri_pkg::IdxW-1:0]-1'b1].red;
                        r_lo_c[1] <= r_tab[r_hi[cri_pkg::IdxW-1:0]-1'b1].green;
                        r_lo_c[2] <= r_tab[r_hi[cri_pkg::IdxW-1:0]-1'b1].blue;
                        r_up_c[0] <= r_tab[r_hi[cri_pkg::IdxW-1:0]].red;
                        r_up_c[1] <= r_tab[r_hi[cri_pkg::IdxW-1:0]].green;
                        r_up_c[2] <= r_tab[r_hi[cri_pkg::IdxW-1:0]].blue;
                        r_comp <= 2'd0;
                        r_state <= S_NEXT;
                    end
                end
                S_NEXT: begin
                    // Divide (up - lo) * t by w; a falling component swaps its ends and uses w - t as t.
                    if (r_up_c[r_comp] >= r_lo_c[r_comp]) r_state <= S_DIV;
                    else begin
                        {r_up_c[r_comp], r_lo_c[r_comp]} <= {r_lo_c[r_comp], r_up_c[r_comp]};
                        r_t <= r_w - r_t;
                        r_state <= S_DIV;
                    end
                end
                S_DIV: r_state <= S_WAIT;
                S_WAIT: begin
                    if (!div_busy) begin
                        if (r_comp == 2'd2) begin
                            r_res <= '{r_out_c[0], r_out_c[1], r_lo_c[2] + div_q,
                                       cri_pkg::StOk};
                            r_state <= S_OUT;
                        end else begin
                            r_out_c[r_comp[0]] <= r_lo_c[r_comp] + div_q;
                            r_comp <= r_comp + 2'd1;
                            r_t <= r_cmd.node.pos - (r_tab[r_hi[cri_pkg::IdxW-1:0]-1'b1].pos);
                            r_state <= S_NEXT;
                        end
                    end
                end
                S_OUT: begin
                    if (out_load) begin
                        r_out <= r_res;
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    `CRI_ASSERT_ALWAYS(a_count_range, i_clk, i_rst_n, r_count <= cri_pkg::CntW'(cri_pkg::MaxNodes))
    `CRI_ASSERT_IMP(a_div_only_lookup, i_clk, i_rst_n, r_state == S_DIV, r_cmd.op == cri_pkg::OpLookup)
    `CRI_ASSERT_IMP(a_div_start_idle, i_clk, i_rst_n, div_start, !div_busy)
endmodule

// ===== rtl/core/cri_front.sv =====
// Front part: accepts items and queues them for the back part.
// Depends on cri_pkg and cri_queue.
module cri_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  cri_pkg::t_cmd i_cmd,
    output logic          o_full,
    input  logic          i_take,
    output logic          o_valid,
    output cri_pkg::t_cmd o_cmd
);
    logic q_empty;

    cri_queue u_q (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_push(i_push), .i_data(i_cmd),
        .o_full(o_full), .i_pop(i_take), .o_empty(q_empty), .o_data(o_cmd)
    );

    assign o_valid = !q_empty;
endmodule
